[sv/stable_priority_queue_assert.svh]
// Assertion macros for the stable priority queue.
// Expects signals clk and rst_n in the scope of use.
`ifndef STABLE_PRIORITY_QUEUE_ASSERT_SVH
`define STABLE_PRIORITY_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
`define SPQ_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("spq check failed");
`define SPQ_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("spq check failed");
`else
`define SPQ_ASSERT_IMP(lbl, ante, cons)
`define SPQ_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

[sv/spq_pkg.sv]
// Shared types and constants for the stable priority queue.
// No dependencies.
`timescale 1ns / 1ps
package spq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int KEY_W     = 8;
  localparam int PAY_W     = 16;
  localparam int OCC_W     = 5;

  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_PRIO = 2'd1,
    OP_POP  = 2'd2,
    OP_PEEK = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic             vld;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } entry_t;

  localparam entry_t ENTRY_NONE = '0;

  // Broadcast command to every cell for one transfer.
  typedef struct packed {
    logic             push;
    logic             prio;
    logic             pop;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } cmd_t;

endpackage

[sv/spq_cell.sv]
// One slot of the queue: holds an entry, compares against the new key,
// shifts toward head or tail with its neighbors. Uses spq_pkg.
`timescale 1ns / 1ps
module spq_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  spq_pkg::cmd_t  cmd,
  input  spq_pkg::entry_t below,    // neighbor nearer the tail
  input  spq_pkg::entry_t above,    // neighbor nearer the head
  input  logic           nolt_in,   // no smaller key in any cell above
  output logic           nolt_out,
  input  logic           mark_in,   // insert point at or below the cell below
  output logic           mark_out,
  output spq_pkg::entry_t ent
);

  spq_pkg::entry_t ent_r;
  spq_pkg::entry_t ent_nxt;
  logic            lt;
  logic            gt;
  logic            cand;

  assign lt       = ent_r.vld && (ent_r.key < cmd.key);
  assign gt       = ent_r.vld && (ent_r.key > cmd.key);
  // greater entry seen before the first smaller one, scanning from head
  assign cand     = cmd.prio && gt && nolt_in;
  assign nolt_out = nolt_in && !lt;
  assign mark_out = mark_in || cand || !ent_r.vld;

  always_comb begin
    ent_nxt = ent_r;
    if (cmd.pop) begin
      ent_nxt = above;
    end else if (cmd.push) begin
      if (mark_in) begin
        ent_nxt = below;
      end else if (mark_out) begin
        ent_nxt.vld     = 1'b1;
        ent_nxt.key     = cmd.key;
        ent_nxt.payload = cmd.payload;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.vld <= 1'b0;
    end else begin
      ent_r.vld <= ent_nxt.vld;
    end
    ent_r.key     <= ent_nxt.key;
    ent_r.payload <= ent_nxt.payload;
  end

  assign ent = ent_r;

endmodule

[sv/stable_priority_queue.sv]
// Top level of the stable priority queue: a row of spq_cell slots plus the
// result register. Uses spq_pkg, spq_cell and stable_priority_queue_assert.svh.
`timescale 1ns / 1ps
`include "stable_priority_queue_assert.svh"

// Bounded priority queue of DEPTH key/payload entries built as a row of cells.
// Cell 0 holds the tail (the entry that pop and peek return); the head is the
// highest occupied cell. Every cell compares its key with the incoming key at
// once; a "no smaller key above" flag ripples from the head down and an
// insert-point mark ripples from the tail up, so one transfer is taken every clock
// cycle while in_stall is low; the output register shows its result next cycle.
// Plain push writes at the head. Priority push lands just tailward of the last
// strictly greater entry seen before the first smaller one (scanning from the
// head), so equal keys keep arrival order. Pop shifts every cell one step
// toward the tail. A push into a full queue is dropped with status full; pop or
// peek on an empty queue reports status empty. Key and payload out are zero
// except for a successful pop or peek. Occupancy is the count after the item,
// modulo 32. in_stall rises only while a result waits and out_stall is high.
module stable_priority_queue #(
  parameter int DEPTH = spq_pkg::DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               in_opcode,
  input  logic [spq_pkg::KEY_W-1:0] in_key,
  input  logic [spq_pkg::PAY_W-1:0] in_payload,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [spq_pkg::KEY_W-1:0] out_key,
  output logic [spq_pkg::PAY_W-1:0] out_payload,
  output logic [1:0]               out_status,
  output logic [spq_pkg::OCC_W-1:0] out_occupancy
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  spq_pkg::entry_t          ent   [DEPTH];
  logic [DEPTH:0]           nolt;
  logic [DEPTH:0]           mark;
  logic [DEPTH-1:0]         vld_vec;
  spq_pkg::cmd_t            cmd;
  spq_pkg::op_t             op;

  logic [CNT_W-1:0]         count_r;
  logic [CNT_W-1:0]         count_nxt;
  logic                     full;
  logic                     empty;
  logic                     in_acc;
  logic                     is_push;

  logic                     out_valid_r;
  logic                     out_valid_nxt;
  logic [spq_pkg::KEY_W-1:0] key_r;
  logic [spq_pkg::KEY_W-1:0] key_nxt;
  logic [spq_pkg::PAY_W-1:0] pay_r;
  logic [spq_pkg::PAY_W-1:0] pay_nxt;
  spq_pkg::status_t         status_r;
  spq_pkg::status_t         status_nxt;
  logic [spq_pkg::OCC_W-1:0] occ_r;

  // Output register frees the input side whenever it is empty or drains.
  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;
  assign op       = spq_pkg::op_t'(in_opcode);
  assign is_push  = (op == spq_pkg::OP_PUSH) || (op == spq_pkg::OP_PRIO);
  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);

  always_comb begin
    cmd.push    = in_acc && is_push && !full;
    cmd.prio    = (op == spq_pkg::OP_PRIO);
    cmd.pop     = in_acc && (op == spq_pkg::OP_POP) && !empty;
    cmd.key     = in_key;
    cmd.payload = in_payload;
  end

  // ripple chains across the row
  assign nolt[DEPTH] = 1'b1;
  assign mark[0]     = 1'b0;

  for (genvar j = 0; j < DEPTH; j++) begin : g_cell
    spq_pkg::entry_t below_ent;
    spq_pkg::entry_t above_ent;
    if (j == 0) begin : g_lo
      assign below_ent = spq_pkg::ENTRY_NONE;
    end else begin : g_mid_lo
      assign below_ent = ent[j-1];
    end
    if (j == DEPTH - 1) begin : g_hi
      assign above_ent = spq_pkg::ENTRY_NONE;
    end else begin : g_mid_hi
      assign above_ent = ent[j+1];
    end

    spq_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cmd      (cmd),
      .below    (below_ent),
      .above    (above_ent),
      .nolt_in  (nolt[j+1]),
      .nolt_out (nolt[j]),
      .mark_in  (mark[j]),
      .mark_out (mark[j+1]),
      .ent      (ent[j])
    );

    assign vld_vec[j] = ent[j].vld;
  end

  always_comb begin
    count_nxt  = count_r;
    key_nxt    = '0;
    pay_nxt    = '0;
    status_nxt = spq_pkg::ST_DONE;
    unique case (op)
      spq_pkg::OP_PUSH, spq_pkg::OP_PRIO: begin
        if (full) begin
          status_nxt = spq_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      spq_pkg::OP_POP, spq_pkg::OP_PEEK: begin
        if (empty) begin
          status_nxt = spq_pkg::ST_EMPTY;
        end else begin
          key_nxt = ent[0].key;
          pay_nxt = ent[0].payload;
          if (op == spq_pkg::OP_POP) begin
            count_nxt = count_r - CNT_W'(1);
          end
        end
      end
      default: begin
        status_nxt = spq_pkg::ST_DONE;
      end
    endcase
  end

  assign out_valid_nxt = in_acc || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        count_r <= count_nxt;
      end
    end
    if (in_acc) begin
      key_r    <= key_nxt;
      pay_r    <= pay_nxt;
      status_r <= status_nxt;
      occ_r    <= spq_pkg::OCC_W'(count_nxt);
    end
  end

  assign out_valid     = out_valid_r;
  assign out_key       = key_r;
  assign out_payload   = pay_r;
  assign out_status    = status_r;
  assign out_occupancy = occ_r;

  // count tracks occupied cells, occupied cells pack from the tail
  `SPQ_ASSERT_IMP(a_count_match, 1'b1, $countones(vld_vec) == int'(count_r))
  `SPQ_ASSERT_IMP(a_packed, 1'b1, (vld_vec & (vld_vec + DEPTH'(1))) == '0)
  `SPQ_ASSERT_NXT(a_full_drop, in_acc && is_push && full, out_status == spq_pkg::ST_FULL)
  `SPQ_ASSERT_NXT(a_pop_dec, cmd.pop, count_r == $past(count_r) - CNT_W'(1))

endmodule
